// File: sv/bgcu_pkg.sv
// Shared constants for the Burgers Godunov cell update block.
`default_nettype none
package bgcu_pkg;

    localparam int VALUE_BITS_DEF = 16;
    localparam int RATIO_BITS     = 16;
    localparam int RATIO_FRAC     = 14;
    localparam logic [RATIO_BITS-1:0] RATIO_RESET = 16'd8192;

    localparam int PHASE_BITS = 2;
    localparam logic [PHASE_BITS-1:0] PHASE_START = 2'd0;
    localparam logic [PHASE_BITS-1:0] PHASE_ONE   = 2'd1;
    localparam logic [PHASE_BITS-1:0] PHASE_RUN   = 2'd2;

    localparam int STATE_BITS = 2;
    localparam logic [STATE_BITS-1:0] ST_IDLE = 2'd0;
    localparam logic [STATE_BITS-1:0] ST_SQ   = 2'd1;
    localparam logic [STATE_BITS-1:0] ST_DIFF = 2'd2;
    localparam logic [STATE_BITS-1:0] ST_OUT  = 2'd3;

endpackage
`default_nettype wire

// File: sv/burgers_godunov_cell_update.sv
// Top level: one Godunov time step of 1D Burgers, one shared multiplier under a sequencer.
// Boundary cell (start of row, or row end before two cells): no result.
// Second cell of a row: states SQ and DIFF (square, flux store), no result.
// Interior cell: states SQ, DIFF and OUT, result in the output register when OUT finds it free;
// the multiplier takes the square, then the flux difference times the step ratio.
// Reset (synchronous, active low) clears state, row phase, peak and ratio (0.5).
`default_nettype none
module burgers_godunov_cell_update
    import bgcu_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_cfg_wr_en,
    input  wire  [RATIO_BITS-1:0]                   i_cfg_wr_data,
    input  wire                                     i_s_tvalid,
    output logic                                    o_s_tready,
    // cell_value [VALUE_BITS-1:0], zero padding above
    input  wire  [((VALUE_BITS+7)/8)*8-1:0]         i_s_tdata,
    input  wire                                     i_s_tlast,
    output logic                                    o_m_tvalid,
    input  wire                                     i_m_tready,
    // updated_value [VALUE_BITS-1:0], row_peak [2*VALUE_BITS-2:VALUE_BITS], zero padding above
    output logic [((2*VALUE_BITS+6)/8)*8-1:0]       o_m_tdata,
    output logic                                    o_m_tlast
);

    localparam int VB    = VALUE_BITS;
    localparam int PB    = VB - 1;
    localparam int FB    = VB + 2;
    localparam int MW    = (VB + 3 > RATIO_BITS + 1) ? VB + 3 : RATIO_BITS + 1;
    localparam int PW    = 2 * MW;
    localparam int SHIFT = VB - 3;
    localparam int OW    = ((2*VALUE_BITS+6)/8)*8;
    localparam logic signed [PW-1:0] SAT_MAX = {{(PW-PB){1'b0}}, {PB{1'b1}}};
    localparam logic signed [PW-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic signed [PW-1:0] HALF    = PW'(1) <<< (RATIO_FRAC - 1);

    logic [RATIO_BITS-1:0]   r_ratio;
    logic [STATE_BITS-1:0]   r_state, n_state;
    logic [PHASE_BITS-1:0]   r_phase;
    logic signed [VB-1:0]    r_held;
    logic [FB-1:0]           r_hflux;
    logic [PB-1:0]           r_peak;
    logic signed [VB-1:0]    r_v;
    logic                    r_last;
    logic [PB-1:0]           r_peak_res;
    logic signed [PW-1:0]    r_prod;
    logic [FB-1:0]           r_fr;
    logic                    r_out_valid;
    logic signed [VB-1:0]    r_out_value;
    logic                    r_out_last;
    logic [PB-1:0]           r_out_peak;

    logic                    accept;
    logic signed [VB-1:0]    in_v;
    logic [PB-1:0]           peak_base;
    logic [PB-1:0]           peak_new;
    logic signed [VB:0]      pair_sum;
    logic signed [VB-1:0]    u;
    logic signed [VB:0]      u_abs;
    logic [VB-1:0]           mag;
    logic [FB-1:0]           fr;
    logic signed [FB:0]      diff;
    logic signed [MW-1:0]    mul_a, mul_b;
    logic signed [PW-1:0]    corr;
    logic signed [PW-1:0]    nv_full;
    logic signed [VB-1:0]    nv;
    logic                    out_free;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign in_v       = i_s_tdata[VB-1:0];
    assign out_free   = !r_out_valid || i_m_tready;

    // running peak, floored at zero
    always_comb begin
        peak_base = (r_phase == PHASE_ONE || r_phase == PHASE_RUN) ? r_peak : '0;
        if ($signed({in_v[VB-1], in_v}) > $signed({2'b00, peak_base})) begin
            peak_new = in_v[PB-1:0];
        end else begin
            peak_new = peak_base;
        end
    end

    // exact Riemann state at the interface between held cell and new cell
    always_comb begin
        pair_sum = {r_held[VB-1], r_held} + {r_v[VB-1], r_v};
        if (r_held > r_v) begin
            u = (pair_sum > 0) ? r_held : r_v;
        end else if (r_held > 0) begin
            u = r_held;
        end else if (r_v < 0) begin
            u = r_v;
        end else begin
            u = '0;
        end
        u_abs = (u < 0) ? -{u[VB-1], u} : {u[VB-1], u};
        mag   = u_abs[VB-1:0];
    end

    assign fr   = r_prod[SHIFT +: FB];
    assign diff = $signed({1'b0, fr}) - $signed({1'b0, r_hflux});

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            ST_SQ: begin
                mul_a = $signed({{(MW-VB){1'b0}}, mag});
                mul_b = $signed({{(MW-VB){1'b0}}, mag});
            end
            ST_DIFF: begin
                mul_a = MW'(diff);
                mul_b = $signed({{(MW-RATIO_BITS){1'b0}}, r_ratio});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // round half up, then saturate
    always_comb begin
        corr    = (r_prod + HALF) >>> RATIO_FRAC;
        nv_full = {{(PW-VB){r_held[VB-1]}}, r_held} - corr;
        if (nv_full > SAT_MAX) begin
            nv = SAT_MAX[VB-1:0];
        end else if (nv_full < SAT_MIN) begin
            nv = SAT_MIN[VB-1:0];
        end else begin
            nv = nv_full[VB-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (r_phase == PHASE_RUN || (r_phase == PHASE_ONE && !i_s_tlast))) begin
                    n_state = ST_SQ;
                end
            end
            ST_SQ:   n_state = ST_DIFF;
            ST_DIFF: n_state = (r_phase == PHASE_RUN) ? ST_OUT : ST_IDLE;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio     <= RATIO_RESET;
            r_state     <= ST_IDLE;
            r_phase     <= PHASE_START;
            r_held      <= '0;
            r_hflux     <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_ratio <= i_cfg_wr_data;
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_v        <= in_v;
                        r_last     <= i_s_tlast;
                        r_peak_res <= i_s_tlast ? peak_new : '0;
                        r_peak     <= i_s_tlast ? '0 : peak_new;
                        if (r_phase == PHASE_ONE && i_s_tlast) begin
                            r_phase <= PHASE_START;
                            r_held  <= '0;
                            r_hflux <= '0;
                        end else if (r_phase != PHASE_ONE && r_phase != PHASE_RUN) begin
                            // start of row: take the left boundary cell
                            r_hflux <= '0;
                            r_held  <= i_s_tlast ? '0 : in_v;
                            r_phase <= i_s_tlast ? PHASE_START : PHASE_ONE;
                        end
                    end
                end
                ST_SQ: begin
                    r_prod <= mul_a * mul_b;
                end
                ST_DIFF: begin
                    r_prod <= mul_a * mul_b;
                    r_fr   <= fr;
                    if (r_phase != PHASE_RUN) begin
                        r_hflux <= fr;
                        r_held  <= r_v;
                        r_phase <= PHASE_RUN;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_out_value <= nv;
                        r_out_last  <= r_last;
                        r_out_peak  <= r_peak_res;
                        if (r_last) begin
                            r_phase <= PHASE_START;
                            r_held  <= '0;
                            r_hflux <= '0;
                        end else begin
                            r_held  <= r_v;
                            r_hflux <= r_fr;
                        end
                    end
                end
                default: begin
                    r_phase <= PHASE_START;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {{(OW-VB-PB){1'b0}}, r_out_peak, r_out_value};

endmodule
`default_nettype wire

// File: verif/tb_burgers_godunov_cell_update.sv
// Self-checking testbench for the Burgers Godunov cell update block: random rows with a scoreboard.
module tb_burgers_godunov_cell_update;
    import bgcu_pkg::*;

    localparam int VB          = VALUE_BITS_DEF;
    localparam int IN_W        = ((VB + 7) / 8) * 8;
    localparam int OUT_W       = ((2 * VB + 6) / 8) * 8;
    localparam longint VAL_MAX = (longint'(1) <<< (VB - 1)) - 1;
    localparam longint VAL_MIN = -VAL_MAX - 1;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct {
        logic [VB-1:0] value;
        logic          done;
        logic [VB-2:0] peak;
    } t_cell_result;

    // Tracks one row of cells and predicts the updated interior values.
    class burgers_row_tracker;
        logic [RATIO_BITS-1:0] ratio       = RATIO_RESET;
        logic signed [VB-1:0]  held_value  = '0;
        logic [VB+1:0]         held_flux   = '0;
        logic [PHASE_BITS-1:0] row_phase   = PHASE_START;
        logic [VB-2:0]         peak_so_far = '0;
        t_cell_result          pending_updates[$];
        int errors          = 0;
        int updates_checked = 0;
        int rows_done       = 0;
        int saturated       = 0;
        int cells_taken     = 0;

        // Flux u*u/2 of the exact Riemann state at the interface
        function logic [VB+1:0] interface_flux(longint a, longint b);
            longint u, mag;
            if (a > b)
                u = (a + b > 0) ? a : b;
            else if (a > 0)
                u = a;
            else if (b < 0)
                u = b;
            else
                u = 0;
            mag = (u < 0) ? -u : u;
            return (VB + 2)'((mag * mag) >> (VB - 3));
        endfunction

        function void set_ratio(logic [RATIO_BITS-1:0] r);
            ratio = r;
        endfunction

        function void clear_row();
            row_phase   = PHASE_START;
            peak_so_far = '0;
            held_value  = '0;
            held_flux   = '0;
        endfunction

        function void note_cell(logic signed [VB-1:0] cell_in, logic last);
            longint v, peak, fr, diff, corr, nv;
            t_cell_result r;
            v = cell_in;
            cells_taken++;
            peak = (row_phase == PHASE_ONE || row_phase == PHASE_RUN) ? longint'(peak_so_far) : 0;
            if (v > peak)
                peak = v;
            if (row_phase == PHASE_RUN) begin
                fr   = interface_flux(held_value, v);
                diff = fr - longint'(held_flux);
                // round to nearest, ties upward
                corr = (diff * longint'(ratio) + (longint'(1) <<< (RATIO_FRAC - 1))) >>> RATIO_FRAC;
                nv   = longint'(held_value) - corr;
                if (nv > VAL_MAX || nv < VAL_MIN)
                    saturated++;
                if (nv > VAL_MAX)
                    nv = VAL_MAX;
                if (nv < VAL_MIN)
                    nv = VAL_MIN;
                r.value = nv[VB-1:0];
                r.done  = last;
                r.peak  = last ? peak[VB-2:0] : '0;
                pending_updates.push_back(r);
                if (last) begin
                    clear_row();
                    rows_done++;
                end else begin
                    held_flux   = fr[VB+1:0];
                    held_value  = v[VB-1:0];
                    peak_so_far = peak[VB-2:0];
                end
            end else if (row_phase == PHASE_ONE) begin
                if (last) begin
                    clear_row();
                end else begin
                    held_flux   = interface_flux(held_value, v);
                    held_value  = v[VB-1:0];
                    peak_so_far = peak[VB-2:0];
                    row_phase   = PHASE_RUN;
                end
            end else begin
                if (last) begin
                    clear_row();
                end else begin
                    held_flux   = '0;
                    held_value  = v[VB-1:0];
                    peak_so_far = peak[VB-2:0];
                    row_phase   = PHASE_ONE;
                end
            end
        endfunction

        function void check_update(logic [OUT_W-1:0] data, logic last);
            t_cell_result want;
            logic [VB-1:0] got_value;
            logic [VB-2:0] got_peak;
            got_value = data[VB-1:0];
            got_peak  = data[2*VB-2:VB];
            if (pending_updates.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer: value %0d done %0b peak %0d",
                         $time, $signed(got_value), last, got_peak);
                return;
            end
            want = pending_updates.pop_front();
            updates_checked++;
            if (got_value !== want.value) begin
                errors++;
                $display("%0t: updated_value expected %0d got %0d",
                         $time, $signed(want.value), $signed(got_value));
            end
            if (last !== want.done) begin
                errors++;
                $display("%0t: row_done expected %0b got %0b", $time, want.done, last);
            end
            if (got_peak !== want.peak) begin
                errors++;
                $display("%0t: row_peak expected %0d got %0d", $time, want.peak, got_peak);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [RATIO_BITS-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tready = 1'b0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire  [OUT_W-1:0]      m_tdata;
    wire                   m_tlast;

    burgers_row_tracker tracker = new;

    int cycle_count = 0;
    int hold_ask    = 0;
    int hold_seen   = 0;
    int long_hold   = 0;
    int stall_left  = 0;
    int ready_left  = 0;

    burgers_godunov_cell_update #(.VALUE_BITS(VB)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .o_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tlast     (s_tlast),
        .o_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (m_tdata),
        .o_m_tlast     (m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d updates outstanding",
                     cycle_count, tracker.pending_updates.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_update(m_tdata, m_tlast);
    end

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [VB-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return VB'($urandom);
        if (r < 55)
            return VB'($urandom_range(0, 4095) - 2048);
        if (r < 80)
            return VB'($urandom_range(0, 32767) - 16384);
        case ($urandom_range(0, 4))
            0:       return VB'(VAL_MAX);
            1:       return VB'(VAL_MIN);
            2:       return '0;
            3:       return '1;
            default: return VB'(1);
        endcase
    endfunction

    // Receiver: bursts of ready, random stalls, and one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            long_hold = LONG_HOLD;
        end
        if (long_hold > 0) begin
            m_tready <= 1'b0;
            long_hold--;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (ready_left > 0) begin
            m_tready <= 1'b1;
            ready_left--;
        end else begin
            m_tready   <= 1'b1;
            ready_left = $urandom_range(0, 40);
            stall_left = pick_gap();
        end
    end

    // Entered and left at a falling edge
    task automatic send_cell(input logic signed [VB-1:0] v, input logic last, input int gap);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = IN_W'(v);
        s_tlast  = last;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        tracker.note_cell(v, last);
        @(negedge i_clk);
    endtask

    task automatic send_row(input logic signed [VB-1:0] vals[$]);
        for (int i = 0; i < vals.size(); i++)
            send_cell(vals[i], i == vals.size() - 1, pick_gap());
    endtask

    // Hold the input until every expected update has arrived, then let the block go quiet
    task automatic settle();
        s_tvalid = 1'b0;
        while (tracker.pending_updates.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_step_ratio(input logic [RATIO_BITS-1:0] r);
        settle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = r;
        @(negedge i_clk);
        cfg_wr_en = 1'b0;
        tracker.set_ratio(r);
    endtask

    task automatic run_rows(input int n_cells, input int hold_at);
        int sent, len, r;
        bit calm;
        sent = 0;
        while (sent < n_cells) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                len = $urandom_range(1, 2);
            else if (r < 90)
                len = $urandom_range(3, 16);
            else
                len = $urandom_range(30, 80);
            calm = ($urandom_range(0, 3) == 0);
            if (hold_at >= 0 && sent >= hold_at && hold_at + len > sent) begin
                // stall the output for a long stretch while cells keep coming
                hold_ask++;
                calm = 1'b1;
                len  = 60;
            end
            for (int i = 0; i < len; i++)
                send_cell(pick_value(), i == len - 1, calm ? 0 : pick_gap());
            sent += len;
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        rst_n = 1'b1;

        // reset ratio: shock and rarefaction branches, extremes, short rows
        send_row('{32767, -32768, 32767, 0, -1});
        send_row('{4096, 8192, -4096, -8192, -4096});
        send_row('{-100, -200, -50});
        send_row('{1234});
        send_row('{-32768, 32767});
        send_row('{4096, -4096, 12345});

        // largest ratio: drive the sum into both saturation limits
        set_step_ratio(16'hFFFF);
        send_row('{0, -32768, 0, 0});
        send_row('{0, 32767, 32767});
        run_rows(300, -1);

        set_step_ratio(16'h0000);
        run_rows(200, -1);

        set_step_ratio(16'h4000);
        run_rows(300, 60);

        repeat (4) begin
            set_step_ratio(RATIO_BITS'($urandom));
            run_rows(250, -1);
        end

        set_step_ratio(16'h0001);
        run_rows(150, -1);

        settle();
        if (tracker.pending_updates.size() != 0)
            $display("%0d expected updates never arrived", tracker.pending_updates.size());
        $display("Covered %0d cells, %0d full rows, %0d updates checked (%0d saturated),",
                 tracker.cells_taken, tracker.rows_done, tracker.updates_checked,
                 tracker.saturated);
        $display("step ratios 0, 1 lsb, 0.5, 1.0, max and random, with stalls on both sides.");
        if (tracker.errors == 0 && tracker.pending_updates.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
